// ===== design/accel_swing_heading_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// accel_swing_heading_tracker_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ACCEL_SWING_HEADING_TRACKER_DEFINES_SVH
`define ACCEL_SWING_HEADING_TRACKER_DEFINES_SVH

// implication in the same cycle
`define HST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define HST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg
// types and constants of the swing heading tracker
// ----------------------------------------------------------------------------
`default_nettype none

package hst_pkg;

	typedef logic signed [9:0] smp_t;
	typedef logic signed [2:0] head_t;

	typedef struct packed {
		head_t heading;
		logic  center;
	} axis_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} st_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE    = 3'd4;

	localparam logic [15:0] CYCLE_RESET = 16'd1500;
	localparam int SWEEP_EDGE = 20;
	localparam int MID_RANK   = 50;
	localparam int FULL_RANK  = 100;

	localparam smp_t  SMP_MISSING = -10'sd1;
	localparam head_t HEAD_LEFT   = -3'sd2;
	localparam head_t HEAD_CLEFT  = -3'sd1;
	localparam head_t HEAD_STEADY = 3'sd0;
	localparam head_t HEAD_CRIGHT = 3'sd1;
	localparam head_t HEAD_RIGHT  = 3'sd2;

endpackage

`default_nettype wire

// ===== design/accel_swing_heading_tracker.sv =====
// ----------------------------------------------------------------------------
// accel_swing_heading_tracker
// swing heading from a sliding window of x/y/z accelerometer samples
// ----------------------------------------------------------------------------
// usage
//   s_* takes one sample transfer: x, y, z (10 bit signed) and a 32 bit tick.
//   m_* returns one result per sample: three headings, three sticky center
//   flags and a missing-sensor flag.
//   cfg_we/cfg_idx/cfg_data write damping limit, per-axis invert and the
//   swing timeout; write only while no sample is in flight.
// timing
//   the windows sit in a row of WINDOW cells; a sample shifts in at the head
//   and a sweep walks the row one cell per cycle, and the result is registered
//   at the end of the sweep. a new sample is taken only once the previous
//   result has moved into the result register. a sample with all axes at -1
//   skips the sweep and goes straight to the result register.
// reset
//   windows, headings, center flags and tick marks clear; the swing starts
//   expecting a right extreme; cycle limit returns to 1500.
// stall
//   the result register holds until m_tready; a next sample can be taken and
//   swept meanwhile, and waits at the end of the sweep for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_swing_heading_tracker #(
	parameter int WINDOW = 16,
	localparam int CNT_W = $clog2(WINDOW + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// sample_x, sample_y, sample_z, now_ticks, zero fill
	input  logic [63:0]                      s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// heading_x, heading_y, heading_z, center_x, center_y, center_z,
	// sensor_missing, zero fill
	output logic [15:0]                      m_tdata,
	input  logic                             cfg_we,
	input  logic [hst_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [hst_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hst_pkg::*;

	st_t  st_q;
	st_t  st_d;
	logic s_acc;
	logic smp_missing;
	logic finish;
	logic m_tvalid_q;
	logic miss_q;
	logic miss_out_q;
	logic start_q;

	smp_t [2:0]  smp_in;
	smp_t [2:0]  val_q;
	logic [31:0] now_q;

	logic [9:0]  damp_q;
	logic [2:0]  inv_q;
	logic [15:0] cyc_q;

	smp_t [2:0]            ent  [0:WINDOW-1];
	logic                  wv   [0:WINDOW];
	smp_t [2:0]            wval [0:WINDOW];
	smp_t [2:0]            wlo  [0:WINDOW];
	smp_t [2:0]            whi  [0:WINDOW];
	logic [2:0][CNT_W-1:0] wcnt [0:WINDOW];

	axis_out_t [2:0] axr;

	assign smp_in[0]   = s_tdata[9:0];
	assign smp_in[1]   = s_tdata[19:10];
	assign smp_in[2]   = s_tdata[29:20];
	assign smp_missing = (smp_in[0] == SMP_MISSING) && (smp_in[1] == SMP_MISSING) &&
		(smp_in[2] == SMP_MISSING);
	assign s_acc       = s_tvalid && s_tready;

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		finish   = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_DONE: begin
				finish = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (s_acc) begin
					st_d = smp_missing ? ST_DONE : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (wv[WINDOW]) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (finish) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			miss_q     <= 1'b0;
			miss_out_q <= 1'b0;
			start_q    <= 1'b0;
		end else begin
			st_q    <= st_d;
			start_q <= s_acc && !smp_missing;
			if (s_acc) begin
				miss_q <= smp_missing;
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
				miss_out_q <= miss_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			val_q <= smp_in;
			now_q <= s_tdata[61:30];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q <= '0;
			inv_q  <= '0;
			cyc_q  <= CYCLE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DAMPING:  damp_q   <= cfg_data[9:0];
				REG_INVERT_X: inv_q[0] <= cfg_data[0];
				REG_INVERT_Y: inv_q[1] <= cfg_data[0];
				REG_INVERT_Z: inv_q[2] <= cfg_data[0];
				REG_CYCLE:    cyc_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// head of the sweep
	assign ent[0]  = smp_in;
	assign wv[0]   = start_q;
	assign wval[0] = val_q;
	assign wlo[0]  = val_q;
	assign whi[0]  = val_q;
	assign wcnt[0] = '0;

	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		if (k < WINDOW - 1) begin : g_mid
			hst_cell #(.WINDOW(WINDOW)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (s_acc && !smp_missing),
				.entry_in  (ent[k]),
				.entry_out (ent[k+1]),
				.v_in      (wv[k]),
				.val_in    (wval[k]),
				.lo_in     (wlo[k]),
				.hi_in     (whi[k]),
				.cnt_in    (wcnt[k]),
				.v_out     (wv[k+1]),
				.val_out   (wval[k+1]),
				.lo_out    (wlo[k+1]),
				.hi_out    (whi[k+1]),
				.cnt_out   (wcnt[k+1])
			);
		end else begin : g_last
			hst_cell #(.WINDOW(WINDOW)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (s_acc && !smp_missing),
				.entry_in  (ent[k]),
				.entry_out (),
				.v_in      (wv[k]),
				.val_in    (wval[k]),
				.lo_in     (wlo[k]),
				.hi_in     (whi[k]),
				.cnt_in    (wcnt[k]),
				.v_out     (wv[k+1]),
				.val_out   (wval[k+1]),
				.lo_out    (wlo[k+1]),
				.hi_out    (whi[k+1]),
				.cnt_out   (wcnt[k+1])
			);
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		hst_axis #(.WINDOW(WINDOW)) u_axis (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (finish && !miss_q),
			.lo     (wlo[WINDOW][a]),
			.hi     (whi[WINDOW][a]),
			.cnt    (wcnt[WINDOW][a]),
			.damp   (damp_q),
			.inv    (inv_q[a]),
			.cyc    (cyc_q),
			.now    (now_q),
			.res    (axr[a])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, miss_out_q, axr[2].center, axr[1].center, axr[0].center,
		axr[2].heading, axr[1].heading, axr[0].heading};

endmodule

`default_nettype wire

// ===== design/hst_cell.sv =====
// ----------------------------------------------------------------------------
// hst_cell
// one window slot for all three axes plus one step of the min/max/rank sweep
// ----------------------------------------------------------------------------
`default_nettype none

module hst_cell #(
	parameter int WINDOW = 16,
	localparam int CNT_W = $clog2(WINDOW + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  hst_pkg::smp_t [2:0]           entry_in,
	output hst_pkg::smp_t [2:0]           entry_out,
	input  logic                          v_in,
	input  hst_pkg::smp_t [2:0]           val_in,
	input  hst_pkg::smp_t [2:0]           lo_in,
	input  hst_pkg::smp_t [2:0]           hi_in,
	input  logic [2:0][CNT_W-1:0]         cnt_in,
	output logic                          v_out,
	output hst_pkg::smp_t [2:0]           val_out,
	output hst_pkg::smp_t [2:0]           lo_out,
	output hst_pkg::smp_t [2:0]           hi_out,
	output logic [2:0][CNT_W-1:0]         cnt_out
);
	import hst_pkg::*;

	smp_t [2:0]            entry_q;
	smp_t [2:0]            lo_d;
	smp_t [2:0]            hi_d;
	logic [2:0][CNT_W-1:0] cnt_d;
	logic                  v_q;
	smp_t [2:0]            val_q;
	smp_t [2:0]            lo_q;
	smp_t [2:0]            hi_q;
	logic [2:0][CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			v_q     <= 1'b0;
		end else begin
			v_q <= v_in;
			if (shift) begin
				entry_q <= entry_in;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo_d[a] = ($signed(entry_q[a]) < $signed(lo_in[a])) ? entry_q[a] : lo_in[a];
			hi_d[a] = ($signed(entry_q[a]) > $signed(hi_in[a])) ? entry_q[a] : hi_in[a];
			cnt_d[a] = cnt_in[a] +
				CNT_W'($signed(val_in[a]) >= $signed(entry_q[a]));
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_in;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		cnt_q <= cnt_d;
	end

	assign entry_out = entry_q;
	assign v_out     = v_q;
	assign val_out   = val_q;
	assign lo_out    = lo_q;
	assign hi_out    = hi_q;
	assign cnt_out   = cnt_q;

endmodule

`default_nettype wire

// ===== design/hst_axis.sv =====
// ----------------------------------------------------------------------------
// hst_axis
// heading decision and swing state of one axis
// ----------------------------------------------------------------------------
`default_nettype none

module hst_axis #(
	parameter int WINDOW = 16,
	localparam int CNT_W = $clog2(WINDOW + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  hst_pkg::smp_t         lo,
	input  hst_pkg::smp_t         hi,
	input  logic [CNT_W-1:0]      cnt,
	input  logic [9:0]            damp,
	input  logic                  inv,
	input  logic [15:0]           cyc,
	input  logic [31:0]           now,
	output hst_pkg::axis_out_t    res
);
	import hst_pkg::*;

	localparam int PW = CNT_W + 7;
	localparam logic [PW-1:0] TH_LEFT  = PW'((SWEEP_EDGE + 1) * WINDOW);
	localparam logic [PW-1:0] TH_MID   = PW'((MID_RANK + 1) * WINDOW);
	localparam logic [PW-1:0] TH_RIGHT = PW'((FULL_RANK - SWEEP_EDGE + 1) * WINDOW);

	head_t       held_q;
	logic        exp_right_q;
	logic [31:0] last_q;
	logic        center_q;

	logic signed [10:0] span;
	logic [PW-1:0]      scaled;
	head_t              h_raw;
	head_t              h_inv;
	head_t              h_fin;
	logic               hit;
	logic [31:0]        elapsed;
	logic               flip;

	always_comb begin
		span    = {hi[9], hi} - {lo[9], lo};
		scaled  = PW'(cnt) * PW'(FULL_RANK);
		elapsed = now - last_q;
		if ($unsigned(span) <= {1'b0, damp}) begin
			h_raw = HEAD_STEADY;
		end else if (scaled < TH_LEFT) begin
			h_raw = HEAD_LEFT;
		end else if (scaled < TH_MID) begin
			h_raw = HEAD_CLEFT;
		end else if (scaled < TH_RIGHT) begin
			h_raw = HEAD_CRIGHT;
		end else begin
			h_raw = HEAD_RIGHT;
		end
		h_inv = inv ? -h_raw : h_raw;
		flip  = ((h_inv < 0) && (held_q > 0)) || ((h_inv > 0) && (held_q < 0));
		hit   = exp_right_q ? (h_inv == HEAD_RIGHT) : (h_inv == HEAD_LEFT);
		h_fin = (hit && (elapsed > {16'd0, cyc})) ? HEAD_STEADY : h_inv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= HEAD_STEADY;
			exp_right_q <= 1'b1;
			last_q      <= '0;
			center_q    <= 1'b0;
		end else if (upd) begin
			held_q <= h_fin;
			if (flip) begin
				center_q <= 1'b1;
			end
			if (hit) begin
				exp_right_q <= !exp_right_q;
				last_q      <= now;
			end
		end
	end

	assign res.heading = held_q;
	assign res.center  = center_q;

endmodule

`default_nettype wire

// ===== design/hst_checker.sv =====
// ----------------------------------------------------------------------------
// hst_checker
// port-level checks of the swing heading tracker
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_swing_heading_tracker_defines.svh"

module hst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import hst_pkg::*;

	logic s_xfer;
	logic s_stall;
	logic m_stall;
	logic head_ok;

	assign s_xfer  = s_tvalid && s_tready;
	assign s_stall = s_tvalid && !s_tready;
	assign m_stall = m_tvalid && !m_tready;

	// every heading within left..right
	assign head_ok =
		(head_t'(m_tdata[2:0]) >= HEAD_LEFT) && (head_t'(m_tdata[2:0]) <= HEAD_RIGHT) &&
		(head_t'(m_tdata[5:3]) >= HEAD_LEFT) && (head_t'(m_tdata[5:3]) <= HEAD_RIGHT) &&
		(head_t'(m_tdata[8:6]) >= HEAD_LEFT) && (head_t'(m_tdata[8:6]) <= HEAD_RIGHT);

	`HST_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata), "result not held")

	`HST_ASSERT_NEXT(a_in_hold, s_stall, s_tvalid && $stable(s_tdata), "sample not held")

	`HST_ASSERT_NEXT(a_busy_after_in, s_xfer, !s_tready, "sample taken while busy")

	`HST_ASSERT_NOW(a_heading_range, m_tvalid, head_ok, "heading outside -2..2")

	`HST_ASSERT_NOW(a_fill_zero, m_tvalid, m_tdata[15:13] == 3'b000, "result fill bits not zero")

endmodule

bind accel_swing_heading_tracker hst_checker u_hst_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the swing heading tracker
// ----------------------------------------------------------------------------
// samples are queued by the stimulus process and sent by a driver with random
// gaps. every accepted transfer is run through a heading tracker kept in the
// bench, and the expected result is queued. a monitor with random back
// pressure compares each result transfer field by field. the registers are
// rewritten between phases, only after every result of the previous phase is in.
// ----------------------------------------------------------------------------

module tb_top;
	import hst_pkg::*;

	localparam int WIN = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 250;

	typedef struct packed {
		logic [2:0] fill;
		logic       missing;
		logic       cz;
		logic       cy;
		logic       cx;
		head_t      hz;
		head_t      hy;
		head_t      hx;
	} heading_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// sample_x, sample_y, sample_z, now_ticks, zero fill
	logic [63:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// heading_x, heading_y, heading_z, center_x, center_y, center_z,
	// sensor_missing, zero fill
	logic [15:0]          m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// tracker state kept by the bench
	smp_t        win_r [3][WIN];
	int          slot_r;
	int          held_r [3];
	int          turn_r [3];
	logic [31:0] mark_r [3];
	bit          seen_r [3];
	logic [9:0]  damp_r;
	bit          inv_r [3];
	logic [15:0] climit_r;

	logic [63:0]  sample_q [$];
	heading_rec_t heading_q [$];
	logic [31:0]  tick_now;
	int           phase_items;
	int           mismatches = 0;
	int           s_gap = 0;
	int           s_calm = 0;
	int           m_wait = 0;
	int           m_calm = 0;
	int           quiet_cycles = 0;

	accel_swing_heading_tracker #(
		.WINDOW(WIN)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic smp_t clamp_smp(input int v);
		if (v > 511)
			return smp_t'(511);
		if (v < -512)
			return smp_t'(-512);
		return smp_t'(v);
	endfunction

	task automatic track_sample(input logic [63:0] d);
		smp_t         s [3];
		logic [31:0]  now;
		logic [31:0]  elapsed;
		heading_rec_t rec;
		bit           miss;
		int           lo, hi, cnt, rank, h;
		s[0] = d[9:0];
		s[1] = d[19:10];
		s[2] = d[29:20];
		now = d[61:30];
		miss = (s[0] == SMP_MISSING) && (s[1] == SMP_MISSING) && (s[2] == SMP_MISSING);
		if (!miss) begin
			slot_r = (slot_r + 1) % WIN;
			for (int a = 0; a < 3; a++) begin
				win_r[a][slot_r] = s[a];
				lo = int'(s[a]);
				hi = int'(s[a]);
				cnt = 0;
				for (int i = 0; i < WIN; i++) begin
					if (int'(win_r[a][i]) < lo)
						lo = int'(win_r[a][i]);
					if (int'(win_r[a][i]) > hi)
						hi = int'(win_r[a][i]);
					if (s[a] >= win_r[a][i])
						cnt++;
				end
				rank = (FULL_RANK * cnt) / WIN;
				if (hi - lo <= int'(damp_r))
					h = int'(HEAD_STEADY);
				else if (rank <= SWEEP_EDGE)
					h = int'(HEAD_LEFT);
				else if (rank <= MID_RANK)
					h = int'(HEAD_CLEFT);
				else if (rank <= FULL_RANK - SWEEP_EDGE)
					h = int'(HEAD_CRIGHT);
				else
					h = int'(HEAD_RIGHT);
				if (inv_r[a])
					h = -h;
				if ((h < 0 && held_r[a] > 0) || (h > 0 && held_r[a] < 0))
					seen_r[a] = 1'b1;
				if (h == turn_r[a]) begin
					elapsed = now - mark_r[a];
					if (elapsed > {16'd0, climit_r})
						h = int'(HEAD_STEADY);
					turn_r[a] = (turn_r[a] == int'(HEAD_RIGHT)) ? int'(HEAD_LEFT) :
						int'(HEAD_RIGHT);
					mark_r[a] = now;
				end
				held_r[a] = h;
			end
		end
		rec = '0;
		rec.hx = head_t'(held_r[0]);
		rec.hy = head_t'(held_r[1]);
		rec.hz = head_t'(held_r[2]);
		rec.cx = seen_r[0];
		rec.cy = seen_r[1];
		rec.cz = seen_r[2];
		rec.missing = miss;
		heading_q.push_back(rec);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				track_sample(s_tdata);
				s_gap = pick_gap(s_calm > 0);
				if (s_calm > 0)
					s_calm--;
				else if ($urandom_range(0, 149) == 0)
					s_calm = $urandom_range(40, 120);
			end
			if (!s_tvalid || s_tready) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					s_tdata <= sample_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		heading_rec_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = heading_rec_t'(m_tdata);
				if (heading_q.size() == 0) begin
					$error("result transfer with no sample pending: %h", m_tdata);
					mismatches++;
				end else begin
					want = heading_q.pop_front();
					check_field("heading_x", int'(want.hx), int'(got.hx));
					check_field("heading_y", int'(want.hy), int'(got.hy));
					check_field("heading_z", int'(want.hz), int'(got.hz));
					check_field("center_x", int'(want.cx), int'(got.cx));
					check_field("center_y", int'(want.cy), int'(got.cy));
					check_field("center_z", int'(want.cz), int'(got.cz));
					check_field("sensor_missing", int'(want.missing), int'(got.missing));
				end
				m_wait = pick_gap(m_calm > 0);
				if (m_calm > 0)
					m_calm--;
				else if ($urandom_range(0, 149) == 0)
					m_calm = $urandom_range(40, 120);
			end
			if (m_wait > 0) begin
				m_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_sample(input int x, input int y, input int z, input logic [31:0] t);
		sample_q.push_back({2'b00, t, clamp_smp(z), clamp_smp(y), clamp_smp(x)});
		phase_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DAMPING:  damp_r = data[9:0];
			REG_INVERT_X: inv_r[0] = data[0];
			REG_INVERT_Y: inv_r[1] = data[0];
			REG_INVERT_Z: inv_r[2] = data[0];
			REG_CYCLE:    climit_r = data;
			default: ;
		endcase
	endtask

	task automatic apply_setup(input logic [15:0] damp, input logic [15:0] ix,
			input logic [15:0] iy, input logic [15:0] iz, input logic [15:0] cyc);
		write_reg(REG_DAMPING, damp);
		write_reg(REG_INVERT_X, ix);
		write_reg(REG_INVERT_Y, iy);
		write_reg(REG_INVERT_Z, iz);
		write_reg(REG_CYCLE, cyc);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || heading_q.size() != 0);
	endtask

	// triangle swing on each axis with its own amplitude and offset
	task automatic queue_swing();
		int len, per, half, step, nz, pos;
		int amp [3];
		int mid [3];
		int v [3];
		len = $urandom_range(8, 48);
		per = 2 * $urandom_range(2, 12);
		half = per / 2;
		step = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 3000) : $urandom_range(5, 250);
		nz = $urandom_range(0, 20);
		for (int a = 0; a < 3; a++) begin
			amp[a] = $urandom_range(0, 511);
			mid[a] = int'($urandom_range(0, 200)) - 100;
		end
		if ($urandom_range(0, 7) == 0)
			tick_now = 32'hFFFF_FFFF - $urandom_range(0, 5000);
		for (int k = 0; k < len; k++) begin
			pos = k % per;
			for (int a = 0; a < 3; a++) begin
				if (pos < half)
					v[a] = -amp[a] + (2 * amp[a] * pos) / half;
				else
					v[a] = amp[a] - (2 * amp[a] * (pos - half)) / half;
				v[a] += mid[a] + int'($urandom_range(0, 2 * nz)) - nz;
			end
			tick_now += step + $urandom_range(0, step / 4);
			push_sample(v[0], v[1], v[2], tick_now);
		end
	endtask

	// nearly constant samples, small spread around a random base per axis
	task automatic queue_flat();
		int len, dev;
		int base [3];
		len = $urandom_range(4, 20);
		dev = $urandom_range(0, 8);
		for (int a = 0; a < 3; a++)
			base[a] = int'($urandom_range(0, 1023)) - 512;
		for (int k = 0; k < len; k++) begin
			tick_now += $urandom_range(1, 400);
			push_sample(base[0] + int'($urandom_range(0, 2 * dev)) - dev,
				base[1] + int'($urandom_range(0, 2 * dev)) - dev,
				base[2] + int'($urandom_range(0, 2 * dev)) - dev, tick_now);
		end
	endtask

	task automatic queue_noise(input int n);
		logic [31:0] t;
		for (int k = 0; k < n; k++) begin
			t = ($urandom_range(0, 1) == 1) ? $urandom : tick_now + $urandom_range(0, 3000);
			push_sample(int'($urandom_range(0, 1023)) - 512, int'($urandom_range(0, 1023)) - 512,
				int'($urandom_range(0, 1023)) - 512, t);
		end
	endtask

	initial begin
		int r;
		for (int a = 0; a < 3; a++) begin
			for (int i = 0; i < WIN; i++)
				win_r[a][i] = '0;
			held_r[a] = int'(HEAD_STEADY);
			turn_r[a] = int'(HEAD_RIGHT);
			mark_r[a] = '0;
			seen_r[a] = 1'b0;
			inv_r[a] = 1'b0;
		end
		slot_r = 0;
		damp_r = '0;
		climit_r = CYCLE_RESET;
		tick_now = '0;
		phase_items = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extra bits masked, writes past the last register ignored
		apply_setup(16'hFC00, 16'hFFFE, 16'hFFFE, 16'hFFFE, CYCLE_RESET);
		for (int j = int'(REG_CYCLE) + 1; j < (1 << CFG_IDX_W); j++)
			write_reg(CFG_IDX_W'(j), 16'hFFFF);
		push_sample(511, -512, 0, 32'd0);
		push_sample(-512, 511, 1, 32'd10);
		push_sample(int'(SMP_MISSING), int'(SMP_MISSING), int'(SMP_MISSING), 32'd20);
		push_sample(int'(SMP_MISSING), int'(SMP_MISSING), 0, 32'd30);
		push_sample(0, int'(SMP_MISSING), int'(SMP_MISSING), 32'd40);
		push_sample(511, 511, 511, 32'd2000);
		push_sample(-512, -512, -512, 32'd2100);
		push_sample(256, -256, 100, 32'hFFFF_FF00);
		push_sample(-256, 256, -100, 32'hFFFF_FFFF);
		push_sample(300, -300, 5, 32'h0000_0100);
		push_sample(-300, 300, -5, 32'h0000_0200);
		push_sample(int'(SMP_MISSING), int'(SMP_MISSING), int'(SMP_MISSING), 32'hFFFF_FFFF);
		push_sample(0, 0, 0, 32'h8000_0000);
		push_sample(170, -170, 85, 32'h5555_5555);
		push_sample(-171, 170, -86, 32'hAAAA_AAAA);
		push_sample(511, -512, 511, 32'h0000_0000);
		wait_idle();

		// directed: two axes inverted, zero swing timeout
		apply_setup(16'd0, 16'd1, 16'd0, 16'd1, 16'd0);
		for (int k = 0; k < 8; k++) begin
			if (k % 2 == 0)
				push_sample(511, -512, 400, 32'd5000 + 32'(k));
			else
				push_sample(-512, 511, -400, 32'd5000 + 32'(k));
		end

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: apply_setup(16'd0, 16'd0, 16'd0, 16'd0, CYCLE_RESET);
				1: apply_setup(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'hFFFF);
				2: apply_setup(16'd30, 16'd1, 16'd0, 16'd1, 16'd0);
				3: apply_setup(16'($urandom_range(0, 120)), 16'($urandom_range(0, 1)),
					16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
					16'($urandom_range(100, 4000)));
				4: apply_setup(16'd1, 16'd0, 16'd1, 16'd0, 16'hFFFF);
				default: apply_setup(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1)),
					16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
					16'($urandom_range(0, 65535)));
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 72)
					queue_swing();
				else if (r < 82)
					queue_flat();
				else if (r < 92)
					queue_noise($urandom_range(1, 8));
				else
					repeat ($urandom_range(1, 3))
						push_sample(int'(SMP_MISSING), int'(SMP_MISSING), int'(SMP_MISSING),
							tick_now + $urandom);
			end
		end

		wait_idle();
		repeat (4 * WIN) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== accel_swing_heading_tracker.f =====
+incdir+design
design/hst_pkg.sv
design/hst_cell.sv
design/hst_axis.sv
design/accel_swing_heading_tracker.sv
design/hst_checker.sv
test/tb_top.sv
